// ===== src/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, constants and round tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       wr_byte;     // write byte at current position
      logic [1:0] wr_sel;      // 0: request byte, 1: pad 0x80, 2: zero, 3: length
      logic       cnt_inc;     // advance bit count
      logic       pos_inc;     // advance block position
      logic       load_work;   // copy chain into work words
      logic       do_round;
      logic       fold;        // add work into chain
      logic       reset_msg;   // restore initial state
      logic       latch_len;   // capture final length
   } cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic [5:0] rnd;
   } status_type;

   localparam logic [1:0] SEL_REQ  = 2'd0;
   localparam logic [1:0] SEL_PAD  = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;
   localparam logic [1:0] SEL_LEN  = 2'd3;

   function automatic logic [31:0] sine_k(input logic [5:0] r);
      logic [31:0] k;
      unique case (r)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_s(input logic [3:0] i);
      logic [4:0] s;
      unique case (i)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

// ===== src/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 engine: controller plus datapath.
// ----------------------------------------------------------------------------
// A byte is taken whenever req_ready is high; the byte that fills a block
// is followed by load, 64 rounds at one per cycle and fold, then idle again.
// End of message: pad and length writes up to one byte per cycle, one or two
// compressions, then four digest words, one per cycle while rsp_ready is high.
// Reset restores the MD5 initial chaining words and a zero bit count.
module md5_message_digest (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  md5_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output md5_pkg::rsp_type  rsp_data
);

   md5_pkg::cmd_type    cmd;
   md5_pkg::status_type status;
   logic [1:0]          emit_idx;
   logic [31:0]         emit_word;

   md5_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .emit_idx, .status, .cmd
   );

   md5_datapath u_dp (
      .clock, .reset, .cmd, .req_byte(req_data.data_byte),
      .emit_idx, .status, .emit_word
   );

   assign rsp_data.digest_word = emit_word;
   assign rsp_data.word_index  = emit_idx;
   assign rsp_data.last_word   = emit_idx == 2'd3;

endmodule

// ===== src/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer memory, bit counter, chaining and working words, round logic.
// ----------------------------------------------------------------------------
module md5_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  md5_pkg::cmd_type     cmd,
   input  logic [7:0]           req_byte,
   input  logic [1:0]           emit_idx,
   output md5_pkg::status_type  status,
   output logic [31:0]          emit_word
);

   logic [31:0] block_mem [0:15];
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] work_ff [4];
   logic [31:0] work_in [4];
   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [3:0]  g_idx;
   logic [31:0] m_word_ff;
   logic [7:0]  wr_data;
   logic [31:0] f_val, sum_val, rot_val;
   logic [4:0]  shamt;
   logic [3:0]  word_addr;
   logic [3:0]  rd_addr;
   logic [5:0]  rnd_next;

   always_comb begin
      unique case (cmd.wr_sel)
         md5_pkg::SEL_REQ:  wr_data = req_byte;
         md5_pkg::SEL_PAD:  wr_data = md5_pkg::PAD_BYTE;
         md5_pkg::SEL_ZERO: wr_data = 8'h00;
         default:           wr_data = len_ff[{pos_ff[2:0], 3'b000} +: 8];
      endcase
   end

   assign word_addr = pos_ff[5:2];

   // Message word index for a given round.
   function automatic logic [3:0] msg_idx(input logic [5:0] r);
      logic [3:0] g;
      unique case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = 4'(5 * r[3:0] + 1);
         2'd2: g = 4'(3 * r[3:0] + 5);
         default: g = 4'(7 * r[3:0]);
      endcase
      return g;
   endfunction

   // Prefetch the message word for the next round while the current one runs.
   assign rnd_next = cmd.load_work ? 6'd0 : 6'(rnd_ff + 6'd1);
   assign g_idx    = msg_idx(rnd_next);
   assign rd_addr  = g_idx;

   always_ff @(posedge clock) begin
      if (cmd.wr_byte) begin
         block_mem[word_addr][{pos_ff[1:0], 3'b000} +: 8] <= wr_data;
      end
      m_word_ff <= block_mem[rd_addr];
      // take the count including a byte that arrives with the end mark
      if (cmd.latch_len) begin
         len_ff <= count_in;
      end
   end

   always_comb begin
      logic [31:0] b, c, d;
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      unique case (rnd_ff[5:4])
         2'd0: f_val = (b & c) | (~b & d);
         2'd1: f_val = (d & b) | (~d & c);
         2'd2: f_val = b ^ c ^ d;
         default: f_val = c ^ (b | ~d);
      endcase
   end

   assign sum_val = work_ff[0] + f_val + md5_pkg::sine_k(rnd_ff) + m_word_ff;
   assign shamt   = md5_pkg::rot_s({rnd_ff[5:4], rnd_ff[1:0]});
   assign rot_val = (sum_val << shamt) | (sum_val >> (6'd32 - {1'b0, shamt}));

   always_comb begin
      chain_in = chain_ff;
      work_in  = work_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + 64'd8;
      end
      if (cmd.pos_inc) begin
         pos_in = 6'(pos_ff + 6'd1);
      end
      if (cmd.load_work) begin
         work_in = chain_ff;
         rnd_in  = 6'd0;
      end
      if (cmd.do_round) begin
         work_in[0] = work_ff[3];
         work_in[1] = work_ff[1] + rot_val;
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         rnd_in     = 6'(rnd_ff + 6'd1);
      end
      if (cmd.fold) begin
         for (int i = 0; i < 4; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.reset_msg) begin
         chain_in = '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
         count_in = '0;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
         work_ff  <= '{default: '0};
         count_ff <= '0;
         pos_ff   <= '0;
         rnd_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         work_ff  <= work_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
      end
   end

   assign status.pos     = pos_ff;
   assign status.rnd     = rnd_ff;
   assign emit_word      = chain_ff[emit_idx];

endmodule

// ===== src/md5_control.sv =====
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte writes, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module md5_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  md5_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          emit_idx,
   input  md5_pkg::status_type status,
   output md5_pkg::cmd_type    cmd
);

   md5_pkg::state_type state_ff, state_in;
   md5_pkg::state_type ret_ff, ret_in;
   logic [1:0] idx_ff, idx_in;
   logic       fin_ff, fin_in;
   logic       req_fire;
   logic       full;

   assign req_fire = req_valid && req_ready;
   assign full     = status.pos == 6'd63;

   // Next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      idx_in   = idx_ff;
      fin_in   = fin_ff;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_fire) begin
               fin_in = req_data.end_of_message;
               if (req_data.byte_valid && full) begin
                  state_in = md5_pkg::ST_INIT;
                  ret_in   = req_data.end_of_message ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
               end else if (req_data.end_of_message) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            // writes 0x80 first, then zeros
            if (full) begin
               state_in = md5_pkg::ST_INIT;
               ret_in   = md5_pkg::ST_PAD;
            end else if (status.pos == 6'd55) begin
               state_in = md5_pkg::ST_LEN;
            end
         end
         md5_pkg::ST_LEN: begin
            if (full) begin
               state_in = md5_pkg::ST_INIT;
               ret_in   = md5_pkg::ST_EMIT;
            end
         end
         md5_pkg::ST_INIT:  state_in = md5_pkg::ST_ROUND;
         md5_pkg::ST_ROUND: begin
            if (status.rnd == 6'd63) begin
               state_in = md5_pkg::ST_FOLD;
            end
         end
         md5_pkg::ST_FOLD: begin
            state_in = ret_ff;
            idx_in   = 2'd0;
         end
         md5_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               idx_in = 2'(idx_ff + 2'd1);
               if (idx_ff == 2'd3) begin
                  state_in = md5_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.latch_len = 1'b1;
               if (req_data.byte_valid) begin
                  cmd.wr_byte = 1'b1;
                  cmd.wr_sel  = md5_pkg::SEL_REQ;
                  cmd.cnt_inc = 1'b1;
                  cmd.pos_inc = 1'b1;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            cmd.wr_byte = 1'b1;
            cmd.wr_sel  = fin_ff ? md5_pkg::SEL_PAD : md5_pkg::SEL_ZERO;
            cmd.pos_inc = 1'b1;
         end
         md5_pkg::ST_LEN: begin
            cmd.wr_byte = 1'b1;
            cmd.wr_sel  = md5_pkg::SEL_LEN;
            cmd.pos_inc = 1'b1;
         end
         md5_pkg::ST_INIT:  cmd.load_work = 1'b1;
         md5_pkg::ST_ROUND: cmd.do_round = 1'b1;
         md5_pkg::ST_FOLD:  cmd.fold = 1'b1;
         md5_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready && idx_ff == 2'd3) begin
               cmd.reset_msg = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         ret_ff   <= md5_pkg::ST_IDLE;
         idx_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
         // pad byte goes out once; later pad cycles write zeros
         fin_ff   <= (state_ff == md5_pkg::ST_PAD) ? 1'b0 : fin_in;
      end
   end

   assign emit_idx = idx_ff;

endmodule
